### hw/rtl/q2e_pkg.sv
// Shared types, constants and helpers of the quaternion to Euler angle converter.
// No dependencies; the files that use this package refer to it by scoped names.
`default_nettype none
package q2e_pkg;

    localparam int IN_FRAC_BITS = 14;
    localparam int CORDIC_STEPS = 16;
    localparam int WORK_FRAC    = 30;
    localparam int WORK_SHIFT   = WORK_FRAC - 2 * IN_FRAC_BITS;
    localparam int SQRT_STEPS   = 31;
    localparam int STEP_W       = 5;

    localparam int VW = 40;   // CORDIC x/y width
    localparam int ZW = 34;   // angle accumulator width, radians * 2^30
    localparam int SW = 36;   // operand width after rescaling

    localparam logic signed [33:0] ONE_P   = 34'sd1 <<< (2 * IN_FRAC_BITS);
    localparam logic signed [ZW-1:0] HALF_PI_W = 34'sd1686629713;
    localparam logic signed [16:0] PI_Q13  = 17'sd25736;
    localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;

    typedef struct packed {
        logic signed [VW-1:0] rol_x;
        logic signed [VW-1:0] rol_y;
        logic signed [ZW-1:0] rol_z;
        logic                 rol_zero;
        logic signed [VW-1:0] yaw_x;
        logic signed [VW-1:0] yaw_y;
        logic signed [ZW-1:0] yaw_z;
        logic                 yaw_zero;
        logic signed [VW-1:0] pit_x;
        logic signed [VW-1:0] pit_y;
        logic signed [ZW-1:0] pit_z;
        logic [60:0]          sq_n;
        logic [61:0]          sq_r;
        logic                 sat;
        logic                 neg;
    } stage_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } vec_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            5'd0:  v = 34'sd843314857;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043837;
            5'd3:  v = 34'sd133525159;
            5'd4:  v = 34'sd67021687;
            5'd5:  v = 34'sd33543516;
            5'd6:  v = 34'sd16775851;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194283;
            5'd9:  v = 34'sd2097149;
            5'd31: v = 34'sd0;
            default: v = 34'sd1 <<< (30 - i);
        endcase
        return v;
    endfunction

    // Moves a vector with negative x into the right half plane.
    function automatic vec_t prerotate(input logic signed [SW-1:0] y,
                                       input logic signed [SW-1:0] x);
        vec_t v;
        v.zero = (x == '0) && (y == '0);
        if (x < 0) begin
            if (y >= 0) begin
                v.x = VW'(y);
                v.y = -VW'(x);
                v.z = HALF_PI_W;
            end else begin
                v.x = -VW'(y);
                v.y = VW'(x);
                v.z = -HALF_PI_W;
            end
        end else begin
            v.x = VW'(x);
            v.y = VW'(y);
            v.z = '0;
        end
        return v;
    endfunction

    // Rounds the accumulated angle to Q3.13 and clamps it to +-lim.
    function automatic logic signed [15:0] round_clamp(input logic signed [ZW-1:0] z,
                                                       input logic signed [16:0] lim);
        logic signed [ZW-1:0] t;
        logic signed [16:0]   q;
        t = (z + 34'sd65536) >>> 17;
        q = t[16:0];
        if (q > lim) begin
            q = lim;
        end else if (q < -lim) begin
            q = -lim;
        end
        return q[15:0];
    endfunction

endpackage
`default_nettype wire

### hw/rtl/q2e_in_if.sv
// Input channel of the converter: one quaternion per beat.
// Depends on nothing.
`default_nettype none
interface q2e_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] q_w;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
    modport source (output valid, q_w, q_x, q_y, q_z, input ready);
    modport sink   (input valid, q_w, q_x, q_y, q_z, output ready);
endinterface
`default_nettype wire

### hw/rtl/q2e_out_if.sv
// Output channel of the converter: one set of Euler angles per beat.
// Depends on nothing.
`default_nettype none
interface q2e_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               pitch_saturated;
    modport source (output valid, roll, pitch, yaw, pitch_saturated, input ready);
    modport sink   (input valid, roll, pitch, yaw, pitch_saturated, output ready);
endinterface
`default_nettype wire

### hw/rtl/q2e_sqrt_cell.sv
// One bit of the pipelined integer square root of the pitch cosine term.
// Depends on q2e_pkg.
`default_nettype none
module q2e_sqrt_cell (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic [q2e_pkg::STEP_W-1:0]         step,
    input  wire logic                               valid_prev,
    input  wire q2e_pkg::stage_t                    data_prev,
    output logic                                    valid_reg,
    output q2e_pkg::stage_t                         data_reg
);
    q2e_pkg::stage_t data_next;
    logic [61:0]     bit_val;
    logic [61:0]     trial;

    always_comb
    begin
        bit_val   = 62'd1 << {step, 1'b0};
        trial     = data_prev.sq_r + bit_val;
        data_next = data_prev;
        if ({1'b0, data_prev.sq_n} >= trial) begin
            data_next.sq_n = data_prev.sq_n - trial[60:0];
            data_next.sq_r = (data_prev.sq_r >> 1) + bit_val;
        end else begin
            data_next.sq_r = data_prev.sq_r >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_prev;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            data_reg <= data_next;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/q2e_cordic_cell.sv
// One vectoring CORDIC iteration applied to the roll, yaw and pitch vectors.
// Depends on q2e_pkg.
`default_nettype none
module q2e_cordic_cell (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic [q2e_pkg::STEP_W-1:0]         step,
    input  wire logic                               valid_prev,
    input  wire q2e_pkg::stage_t                    data_prev,
    output logic                                    valid_reg,
    output q2e_pkg::stage_t                         data_reg
);
    q2e_pkg::stage_t      data_next;
    logic signed [q2e_pkg::ZW-1:0] ang;

    always_comb
    begin
        ang       = q2e_pkg::atan_entry(step);
        data_next = data_prev;
        if (data_prev.rol_y >= 0) begin
            data_next.rol_x = data_prev.rol_x + (data_prev.rol_y >>> step);
            data_next.rol_y = data_prev.rol_y - (data_prev.rol_x >>> step);
            data_next.rol_z = data_prev.rol_z + ang;
        end else begin
            data_next.rol_x = data_prev.rol_x - (data_prev.rol_y >>> step);
            data_next.rol_y = data_prev.rol_y + (data_prev.rol_x >>> step);
            data_next.rol_z = data_prev.rol_z - ang;
        end
        if (data_prev.yaw_y >= 0) begin
            data_next.yaw_x = data_prev.yaw_x + (data_prev.yaw_y >>> step);
            data_next.yaw_y = data_prev.yaw_y - (data_prev.yaw_x >>> step);
            data_next.yaw_z = data_prev.yaw_z + ang;
        end else begin
            data_next.yaw_x = data_prev.yaw_x - (data_prev.yaw_y >>> step);
            data_next.yaw_y = data_prev.yaw_y + (data_prev.yaw_x >>> step);
            data_next.yaw_z = data_prev.yaw_z - ang;
        end
        if (data_prev.pit_y >= 0) begin
            data_next.pit_x = data_prev.pit_x + (data_prev.pit_y >>> step);
            data_next.pit_y = data_prev.pit_y - (data_prev.pit_x >>> step);
            data_next.pit_z = data_prev.pit_z + ang;
        end else begin
            data_next.pit_x = data_prev.pit_x - (data_prev.pit_y >>> step);
            data_next.pit_y = data_prev.pit_y + (data_prev.pit_x >>> step);
            data_next.pit_z = data_prev.pit_z - ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_prev;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            data_reg <= data_next;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/quaternion_to_euler_angles.sv
// Quaternion (Q1.14) to roll, pitch and yaw (Q3.13) converter, fully pipelined.
// Stages: products, sums, square, setup, 31 square-root cells,
// 16 CORDIC cells and the output register. One beat is accepted every cycle;
// the whole chain holds when the output register is full and not taken.
// rst_n clears all valid bits asynchronously; data registers are not reset.
// Depends on q2e_pkg, q2e_in_if, q2e_out_if, q2e_sqrt_cell and q2e_cordic_cell.
`default_nettype none
module quaternion_to_euler_angles (
    input  wire logic  clk,
    input  wire logic  rst_n,
    q2e_in_if.sink     din,
    q2e_out_if.source  dout
);
    localparam int NSQ = q2e_pkg::SQRT_STEPS;
    localparam int NCO = q2e_pkg::CORDIC_STEPS;

    logic en;

    // products
    logic               v0_reg;
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg;
    logic signed [31:0] wz_reg, xy_reg, zz_reg;
    // sums, rescaled
    logic                                v1_reg;
    logic signed [q2e_pkg::SW-1:0]       sr_reg, cr_reg, sy_reg, cy_reg, sp_reg;
    logic                                sat1_reg, neg1_reg;
    logic [29:0]                         smag_reg;
    // square
    logic                                v2_reg;
    logic signed [q2e_pkg::SW-1:0]       sr2_reg, cr2_reg, sy2_reg, cy2_reg, sp2_reg;
    logic                                sat2_reg, neg2_reg;
    logic [59:0]                         sq_reg;
    // setup
    logic            v3_reg;
    q2e_pkg::stage_t d3_reg, d3_next;

    logic            sv  [NSQ+1];
    q2e_pkg::stage_t sd  [NSQ+1];
    logic            cv  [NCO+1];
    q2e_pkg::stage_t cd  [NCO+1];

    logic               out_valid_reg;
    logic signed [15:0] roll_reg, yaw_reg, roll_next, yaw_next, pitch_full;
    logic signed [14:0] pitch_reg;
    logic               sat_reg;

    logic signed [33:0] sr1, cr1, sp1, sy1, cy1;
    logic signed [q2e_pkg::SW-1:0] sp1w;
    q2e_pkg::vec_t rv, yv;

    assign en        = !out_valid_reg || dout.ready;
    assign din.ready = en;

    always_ff @(posedge clk)
    begin
        if (en) begin
            wx_reg <= din.q_w * din.q_x;
            yz_reg <= din.q_y * din.q_z;
            xx_reg <= din.q_x * din.q_x;
            yy_reg <= din.q_y * din.q_y;
            wy_reg <= din.q_w * din.q_y;
            zx_reg <= din.q_z * din.q_x;
            wz_reg <= din.q_w * din.q_z;
            xy_reg <= din.q_x * din.q_y;
            zz_reg <= din.q_z * din.q_z;
        end
    end

    always_comb
    begin
        sr1  = (34'(wx_reg) + 34'(yz_reg)) <<< 1;
        cr1  = q2e_pkg::ONE_P - ((34'(xx_reg) + 34'(yy_reg)) <<< 1);
        sp1  = (34'(wy_reg) - 34'(zx_reg)) <<< 1;
        sy1  = (34'(wz_reg) + 34'(xy_reg)) <<< 1;
        cy1  = q2e_pkg::ONE_P - ((34'(yy_reg) + 34'(zz_reg)) <<< 1);
        sp1w = q2e_pkg::SW'(sp1) <<< q2e_pkg::WORK_SHIFT;
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            sr_reg   <= q2e_pkg::SW'(sr1) <<< q2e_pkg::WORK_SHIFT;
            cr_reg   <= q2e_pkg::SW'(cr1) <<< q2e_pkg::WORK_SHIFT;
            sy_reg   <= q2e_pkg::SW'(sy1) <<< q2e_pkg::WORK_SHIFT;
            cy_reg   <= q2e_pkg::SW'(cy1) <<< q2e_pkg::WORK_SHIFT;
            sp_reg   <= sp1w;
            // The magnitude test is exact on the unscaled term.
            sat1_reg <= (sp1 >= q2e_pkg::ONE_P) || (sp1 <= -q2e_pkg::ONE_P);
            neg1_reg <= sp1[33];
            smag_reg <= sp1w[q2e_pkg::SW-1] ? 30'(-sp1w) : sp1w[29:0];

            sr2_reg  <= sr_reg;
            cr2_reg  <= cr_reg;
            sy2_reg  <= sy_reg;
            cy2_reg  <= cy_reg;
            sp2_reg  <= sp_reg;
            sat2_reg <= sat1_reg;
            neg2_reg <= neg1_reg;
            sq_reg   <= smag_reg * smag_reg;

            d3_reg   <= d3_next;
        end
    end

    always_comb
    begin
        rv = q2e_pkg::prerotate(sr2_reg, cr2_reg);
        yv = q2e_pkg::prerotate(sy2_reg, cy2_reg);
        d3_next.rol_x    = rv.x;
        d3_next.rol_y    = rv.y;
        d3_next.rol_z    = rv.z;
        d3_next.rol_zero = rv.zero;
        d3_next.yaw_x    = yv.x;
        d3_next.yaw_y    = yv.y;
        d3_next.yaw_z    = yv.z;
        d3_next.yaw_zero = yv.zero;
        d3_next.pit_x    = '0;
        d3_next.pit_y    = q2e_pkg::VW'(sp2_reg);
        d3_next.pit_z    = '0;
        d3_next.sq_n     = (61'd1 << 60) - 61'(sq_reg);
        d3_next.sq_r     = '0;
        d3_next.sat      = sat2_reg;
        d3_next.neg      = neg2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= din.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign sv[0] = v3_reg;
    assign sd[0] = d3_reg;

    genvar k;
    generate
        for (k = 0; k < NSQ; k++) begin : g_sqrt
            q2e_sqrt_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .en         (en),
                .step       (q2e_pkg::STEP_W'(NSQ - 1 - k)),
                .valid_prev (sv[k]),
                .data_prev  (sd[k]),
                .valid_reg  (sv[k+1]),
                .data_reg   (sd[k+1])
            );
        end
    endgenerate

    // The root becomes the pitch cosine; it is never negative, so no prerotation.
    always_comb
    begin
        cd[0]       = sd[NSQ];
        cd[0].pit_x = q2e_pkg::VW'(sd[NSQ].sq_r);
    end
    assign cv[0] = sv[NSQ];

    generate
        for (k = 0; k < NCO; k++) begin : g_cordic
            q2e_cordic_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .en         (en),
                .step       (q2e_pkg::STEP_W'(k)),
                .valid_prev (cv[k]),
                .data_prev  (cd[k]),
                .valid_reg  (cv[k+1]),
                .data_reg   (cd[k+1])
            );
        end
    endgenerate

    always_comb
    begin
        roll_next = cd[NCO].rol_zero ? 16'sd0
                  : q2e_pkg::round_clamp(cd[NCO].rol_z, q2e_pkg::PI_Q13);
        yaw_next  = cd[NCO].yaw_zero ? 16'sd0
                  : q2e_pkg::round_clamp(cd[NCO].yaw_z, q2e_pkg::PI_Q13);
        if (cd[NCO].sat) begin
            pitch_full = cd[NCO].neg ? -16'sd12868 : 16'sd12868;
        end else begin
            pitch_full = q2e_pkg::round_clamp(cd[NCO].pit_z, q2e_pkg::HALF_PI_Q13);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= cv[NCO];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            roll_reg  <= roll_next;
            yaw_reg   <= yaw_next;
            pitch_reg <= pitch_full[14:0];
            sat_reg   <= cd[NCO].sat;
        end
    end

    assign dout.valid           = out_valid_reg;
    assign dout.roll            = roll_reg;
    assign dout.pitch           = pitch_reg;
    assign dout.yaw             = yaw_reg;
    assign dout.pitch_saturated = sat_reg;

    a_sat_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && sat_reg |-> (pitch_reg == 15'sd12868 || pitch_reg == -15'sd12868))
        else $error("saturated pitch is not half pi");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (pitch_reg <= 15'sd12868 && pitch_reg >= -15'sd12868))
        else $error("pitch out of range");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (roll_reg <= 16'sd25736 && roll_reg >= -16'sd25736
                           && yaw_reg <= 16'sd25736 && yaw_reg >= -16'sd25736))
        else $error("roll or yaw out of range");

endmodule
`default_nettype wire

### test/q2e_scoreboard.sv
// Scoreboard package for the quaternion to Euler angle converter: the angle type
// and a class that queues expected angles. Depends on nothing.
`timescale 1ns / 100ps
package q2e_sb_pkg;
    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               sat;
    } angles_t;

    class q2e_scoreboard;
        angles_t pending_angles[$];
        int      error_count;

        function new();
            error_count = 0;
        endfunction

        function void note_input(angles_t a);
            pending_angles.insert(pending_angles.size(), a);
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            error_count++;
        endtask

        task check_result(angles_t got);
            angles_t exp_a;
            if (pending_angles.size() == 0) begin
                report($sformatf("unexpected result roll=%0d", got.roll));
                return;
            end
            exp_a = pending_angles.pop_front();
            if (got.roll !== exp_a.roll)
                report($sformatf("roll got %0d want %0d", got.roll, exp_a.roll));
            if (got.pitch !== exp_a.pitch)
                report($sformatf("pitch got %0d want %0d", got.pitch, exp_a.pitch));
            if (got.yaw !== exp_a.yaw)
                report($sformatf("yaw got %0d want %0d", got.yaw, exp_a.yaw));
            if (got.sat !== exp_a.sat)
                report($sformatf("sat got %0b want %0b", got.sat, exp_a.sat));
        endtask
    endclass
endpackage

### test/quaternion_to_euler_angles_tb.sv
// Testbench of quaternion_to_euler_angles: directed and random quaternions, bursty
// input, stalling output, predicted angles checked in order. Depends on the RTL files.
`timescale 1ns / 100ps
module quaternion_to_euler_angles_tb;
    localparam int NUM_RANDOM = 1900;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 80;

    logic clk;
    logic rst_n;
    q2e_in_if  din();
    q2e_out_if dout();

    quaternion_to_euler_angles uut (.clk(clk), .rst_n(rst_n), .din(din), .dout(dout));

    q2e_sb_pkg::q2e_scoreboard sb;
    bit            stim_done;
    bit            hold_long;
    int            idle_cycles;

    const longint HALF_PI_RAD = 64'sd1686629713;
    longint atan_lut[32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
        128, 64, 32, 16, 8, 4, 2, 1, 0};

    initial clk = 0;
    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    function automatic longint scale_work(longint v);
        int sh;
        sh = q2e_pkg::WORK_FRAC - 2 * q2e_pkg::IN_FRAC_BITS;
        if (sh >= 0)
            return v <<< sh;
        return v >>> (-sh);
    endfunction

    function automatic longint floor_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint a;
        longint t;
        longint dx;
        longint dy;
        a = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; a = HALF_PI_RAD;
            end
            else
            begin
                t = x; x = -y; y = t; a = -HALF_PI_RAD;
            end
        end
        for (int i = 0; i < q2e_pkg::CORDIC_STEPS && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; a += atan_lut[i];
            end
            else
            begin
                x -= dx; y += dy; a -= atan_lut[i];
            end
        end
        a = (a + 65536) >>> 17;
        if (a > 25736) a = 25736;
        if (a < -25736) a = -25736;
        return a;
    endfunction

    function automatic q2e_sb_pkg::angles_t predict_angles(
        logic signed [15:0] qw, logic signed [15:0] qx,
        logic signed [15:0] qy, logic signed [15:0] qz);
        q2e_sb_pkg::angles_t r;
        longint w, x, y, z, one, sr, cr, sp, sy, cy, p, s, mag;
        longint unsigned sq;
        w = qw; x = qx; y = qy; z = qz;
        one = 64'sd1 <<< (2 * q2e_pkg::IN_FRAC_BITS);
        sr = 2 * (w * x + y * z);
        cr = one - 2 * (x * x + y * y);
        sp = 2 * (w * y - z * x);
        sy = 2 * (w * z + x * y);
        cy = one - 2 * (y * y + z * z);
        r.roll = 16'(vector_angle(scale_work(sr), scale_work(cr)));
        r.yaw = 16'(vector_angle(scale_work(sy), scale_work(cy)));
        mag = sp < 0 ? -sp : sp;
        if (mag >= one)
        begin
            p = sp < 0 ? -12868 : 12868;
            r.sat = 1'b1;
        end
        else
        begin
            s = scale_work(sp);
            sq = s < 0 ? -s : s;
            p = vector_angle(s, floor_sqrt((64'd1 << 60) - sq * sq));
            if (p > 12868) p = 12868;
            if (p < -12868) p = -12868;
            r.sat = 1'b0;
        end
        r.pitch = 15'(p);
        return r;
    endfunction

    // Holds valid high until the beat is taken.
    task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        din.valid <= 1'b1;
        din.q_w <= w;
        din.q_x <= x;
        din.q_y <= y;
        din.q_z <= z;
        @(posedge clk);
        while (!din.ready)
            @(posedge clk);
        sb.note_input(predict_angles(w, x, y, z));
    endtask

    task automatic gap(int n);
        if (n > 0)
        begin
            din.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [15:0] rand_comp(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(32768, 0) - 16384);
            default: return 16'($urandom_range(400, 0) - 200);
        endcase
    endfunction

    // Unit quaternion built from random components by normalizing in real arithmetic.
    task automatic send_unit();
        real a, b, c, d, n;
        a = $itor($urandom_range(2000, 0)) - 1000.0;
        b = $itor($urandom_range(2000, 0)) - 1000.0;
        c = $itor($urandom_range(2000, 0)) - 1000.0;
        d = $itor($urandom_range(2000, 0)) - 1000.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n == 0.0)
        begin
            a = 1.0; n = 1.0;
        end
        send_quat(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
                  16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)));
    endtask

    initial
    begin
        int burst;
        sb = new();
        rst_n = 0;
        din.valid = 0;
        din.q_w = 0;
        din.q_x = 0;
        din.q_y = 0;
        din.q_z = 0;
        stim_done = 0;
        hold_long = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // Identity, zero, extremes, gimbal lock both signs, negative x with zero y.
        send_quat(16384, 0, 0, 0);
        send_quat(0, 0, 0, 0);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_quat(16384, 16384, 16384, 16384);
        send_quat(-16384, -16384, -16384, -16384);
        send_quat(11585, 0, 11585, 0);
        send_quat(11585, 0, -11585, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(0, 0, 16384, 0);
        send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_quat(8192, 8192, 8192, 8192);
        send_quat(8192, -8192, 8192, 8192);
        send_quat(1, -1, 1, -1);
        send_quat(16383, 1, 0, 0);
        send_quat(0, 11585, 11585, 0);
        gap(3);
        for (int i = 0; i < NUM_RANDOM; )
        begin
            burst = $urandom_range(40, 1);
            for (int k = 0; k < burst && i < NUM_RANDOM; k++, i++)
            begin
                if ($urandom_range(9, 0) < 6)
                    send_unit();
                else
                    send_quat(rand_comp($urandom_range(2, 0)), rand_comp($urandom_range(2, 0)),
                              rand_comp($urandom_range(2, 0)), rand_comp($urandom_range(2, 0)));
                if (i == 600)
                    hold_long = 1;
            end
            if ($urandom_range(3, 0) != 0)
                gap($urandom_range(6, 1));
        end
        din.valid <= 1'b0;
        stim_done = 1;
    end

    // Receiver: random stalls in runs, plus one long hold-off.
    initial
    begin
        int stall_left;
        dout.ready = 0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                hold_long = 0;
                dout.ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                dout.ready <= 1'b0;
            end
            else if ($urandom_range(15, 0) == 0)
            begin
                stall_left = $urandom_range(8, 0);
                dout.ready <= 1'b0;
            end
            else
                dout.ready <= ($urandom_range(9, 0) != 0) || ($urandom_range(1, 0) == 0);
        end
    end

    always @(posedge clk)
    begin
        q2e_sb_pkg::angles_t got;
        if (rst_n && dout.valid && dout.ready)
        begin
            got.roll = dout.roll;
            got.pitch = dout.pitch;
            got.yaw = dout.yaw;
            got.sat = dout.pitch_saturated;
            sb.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (din.valid && din.ready) || (dout.valid && dout.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            if (stim_done && sb.pending_angles.size() == 0)
            begin
                repeat (DRAIN_CYCLES) @(posedge clk);
                if (sb.error_count == 0)
                    $display("Testbench completed without errors");
                else
                    $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end
endmodule
